[design/spectrum_whitespace_run_detector_macros.svh]
// Assertion macros shared by the whitespace run detector modules.
`ifndef SPECTRUM_WHITESPACE_RUN_DETECTOR_MACROS_SVH
`define SPECTRUM_WHITESPACE_RUN_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Invariant checked at every clock edge outside reset.
`define SWRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define SWRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SWRD_ASSERT(label, prop, msg)
`define SWRD_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

[design/swrd_pkg.sv]
// Types and constants of the whitespace run detector.
package swrd_pkg;

    localparam int BINS       = 4096;
    localparam int HIST_DEPTH = 65536;

    localparam int BIN_W   = 12;
    localparam int RUN_W   = 20;
    localparam int FRAME_W = 32;
    localparam int HIDX_W  = 16;
    localparam int SUM_W   = 48;
    localparam int GUARD_W = 11;

    localparam int CNT_AW  = $clog2(BINS);
    localparam int HIST_AW = $clog2(HIST_DEPTH);

    // The clearing pass covers the larger of the two memories.
    localparam int CLR_LEN = (BINS > HIST_DEPTH) ? BINS : HIST_DEPTH;
    localparam int CLR_AW  = $clog2(CLR_LEN);

    localparam int OUT_DEPTH = 4;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [RUN_W-1:0] RUN_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_READ     = 1'b1;
    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [CLR_AW-1:0] addr;
    } t_clear;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [RUN_W-1:0]   run_length;
        logic [BIN_W-1:0]   event_bin;
        logic [FRAME_W-1:0] event_frame;
        logic               overflow;
        logic               add;
        logic [HIST_AW-1:0] hist_addr;
    } t_hist_req;

    typedef struct packed {
        logic               result_kind;
        logic [RUN_W-1:0]   run_length;
        logic [BIN_W-1:0]   event_bin;
        logic [FRAME_W-1:0] event_frame;
        logic               hist_overflow;
        logic [SUM_W-1:0]   hist_value;
    } t_result;

endpackage

[design/spectrum_whitespace_run_detector.sv]
// Top level of the spectrum whitespace run detector: registers, clearing pass and pipeline.
//
//  channel | direction | handshake                    | contents
//  --------+-----------+------------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready      | command, ws_flag, bin, frame, index
//  out     | from block| o_out_valid / i_out_ready    | kind, run, bin, frame, overflow, sum
//  config  | to block  | psel / penable / pready      | guard_bins at 0, histogram_enable at 4
//
// One item enters per clock while o_in_ready is high. An item is registered into the
// run counter stage, then into the histogram stage, and its result is written into the
// result queue, whose head drives the output. Both stages read their memory as an item
// enters and write it back as the item leaves, with a forward path for back-to-back
// items on the same entry.
// After reset the block clears both memories, one entry per cycle, over all 65536
// entries of the larger one, and accepts no item meanwhile; configuration writes are
// taken throughout. Apart from that pass, input is held off only when the four-entry
// result queue could overflow because the output side is stalling.
`include "spectrum_whitespace_run_detector_macros.svh"

module spectrum_whitespace_run_detector import swrd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic               i_ws_flag,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic [FRAME_W-1:0] i_frame_number,
    input  logic [HIDX_W-1:0]  i_hist_index,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_result_kind,
    output logic [RUN_W-1:0]   o_run_length,
    output logic [BIN_W-1:0]   o_event_bin,
    output logic [FRAME_W-1:0] o_event_frame,
    output logic               o_hist_overflow,
    output logic [SUM_W-1:0]   o_hist_value,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic REG_GUARD_BINS  = 1'b0;
    localparam logic REG_HIST_ENABLE = 1'b1;

    localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(409);
    localparam logic [CLR_AW-1:0]  CLR_LAST    = CLR_AW'(CLR_LEN - 1);
    localparam int                 PEND_W      = $clog2(OUT_DEPTH + 3);

    logic [GUARD_W-1:0] r_guard;
    logic               r_hist_en;
    logic               r_clr_busy;
    logic [CLR_AW-1:0]  r_clr_addr;
    logic               r_acc_d1;
    logic               r_acc_d2;

    logic              in_acc;
    logic              cfg_wr;
    logic              reg_sel;
    t_clear            clear;
    t_hist_req         req;
    logic              push;
    t_result           res;
    t_result           out_data;
    logic [OCNT_W-1:0] q_count;
    logic [PEND_W-1:0] pending;

    // Items in either stage count against the queue as if each made a result.
    always_comb begin
        pending    = PEND_W'(r_acc_d1) + PEND_W'(r_acc_d2) + PEND_W'(q_count);
        o_in_ready = !r_clr_busy && (pending < PEND_W'(OUT_DEPTH));
        in_acc     = i_in_valid && o_in_ready;

        clear.valid = r_clr_busy;
        clear.addr  = r_clr_addr;
    end

    // Configuration port: no wait states, register index from the word address.
    always_comb begin
        pready  = 1'b1;
        reg_sel = paddr[2];
        cfg_wr  = psel && penable && pwrite && pready;
        unique case (reg_sel)
            REG_GUARD_BINS:  prdata = 32'(r_guard);
            REG_HIST_ENABLE: prdata = 32'(r_hist_en);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard   <= GUARD_RESET;
            r_hist_en <= 1'b1;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_GUARD_BINS:  r_guard   <= pwdata[GUARD_W-1:0];
                REG_HIST_ENABLE: r_hist_en <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Clearing pass after reset, then the credit bookkeeping of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_acc_d1   <= 1'b0;
            r_acc_d2   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_acc_d1 <= in_acc;
            r_acc_d2 <= r_acc_d1;
        end
    end

    swrd_run_stage u_run (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (clear),
        .i_acc          (in_acc),
        .i_command      (i_command),
        .i_ws_flag      (i_ws_flag),
        .i_bin_index    (i_bin_index),
        .i_frame_number (i_frame_number),
        .i_hist_index   (i_hist_index),
        .i_guard_bins   (r_guard),
        .i_hist_enable  (r_hist_en),
        .o_req          (req)
    );

    swrd_hist_stage u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clear),
        .i_req   (req),
        .o_push  (push),
        .o_res   (res)
    );

    swrd_out_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data),
        .o_count (q_count)
    );

    always_comb begin
        o_result_kind   = out_data.result_kind;
        o_run_length    = out_data.run_length;
        o_event_bin     = out_data.event_bin;
        o_event_frame   = out_data.event_frame;
        o_hist_overflow = out_data.hist_overflow;
        o_hist_value    = out_data.hist_value;
    end

    `SWRD_ASSERT_IMP(a_quiet_clear, r_clr_busy, !o_out_valid && !r_acc_d1, "activity during the clearing pass")
    `SWRD_ASSERT_IMP(a_ready_after_clear, $fell(r_clr_busy), o_in_ready, "input held off after the clearing pass")

endmodule

[design/swrd_run_stage.sv]
// Run counter memory and the detection stage that reads, updates and writes it back.
`include "spectrum_whitespace_run_detector_macros.svh"

module swrd_run_stage import swrd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_clear             i_clear,
    input  logic               i_acc,
    input  logic               i_command,
    input  logic               i_ws_flag,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic [FRAME_W-1:0] i_frame_number,
    input  logic [HIDX_W-1:0]  i_hist_index,
    input  logic [GUARD_W-1:0] i_guard_bins,
    input  logic               i_hist_enable,
    output t_hist_req          o_req
);

    logic [RUN_W-1:0] r_mem [BINS];

    logic               r_v;
    logic               r_cmd;
    logic               r_ws;
    logic [BIN_W-1:0]   r_bin;
    logic [FRAME_W-1:0] r_frame;
    logic [HIDX_W-1:0]  r_hidx;
    logic [RUN_W-1:0]   r_rd;
    logic               r_fwd;
    logic [RUN_W-1:0]   r_fwd_val;

    logic              in_range;
    logic              item_we;
    logic [RUN_W-1:0]  count;
    logic [RUN_W-1:0]  n_count;
    logic [RUN_W-1:0]  slot;
    logic              slot_over;
    logic              active;
    logic              is_event;
    logic              is_read;
    logic              read_over;
    logic              mem_we;
    logic [CNT_AW-1:0] mem_wa;
    logic [RUN_W-1:0]  mem_wd;

    always_comb begin
        in_range  = 32'(r_bin) < BINS;
        item_we   = r_v && (r_cmd == CMD_SAMPLE) && in_range;
        // A sample of the same bin in the previous cycle has not reached memory yet.
        count     = r_fwd ? r_fwd_val : r_rd;
        n_count   = r_ws ? ((count == RUN_MAX) ? RUN_MAX : count + 1'b1) : '0;
        active    = (2 * 32'(i_guard_bins) < BINS) &&
                    (32'(r_bin) >= 32'(i_guard_bins)) &&
                    (32'(r_bin) + 32'(i_guard_bins) < BINS);
        is_event  = item_we && active && !r_ws && (count != '0);
        slot      = count - 1'b1;
        slot_over = 32'(slot) >= HIST_DEPTH;
        is_read   = r_v && (r_cmd == CMD_READ);
        read_over = 32'(r_hidx) >= HIST_DEPTH;

        o_req.valid       = is_event || is_read;
        o_req.kind        = is_read ? KIND_READOUT : KIND_EVENT;
        o_req.run_length  = is_event ? count : '0;
        o_req.event_bin   = is_event ? r_bin : '0;
        o_req.event_frame = is_event ? r_frame : '0;
        o_req.overflow    = is_read ? read_over : (i_hist_enable && slot_over);
        o_req.add         = is_event && i_hist_enable && !slot_over;
        o_req.hist_addr   = is_read ? HIST_AW'(r_hidx) : HIST_AW'(slot);

        if (i_clear.valid) begin
            mem_we = 32'(i_clear.addr) < BINS;
            mem_wa = CNT_AW'(i_clear.addr);
            mem_wd = '0;
        end else begin
            mem_we = item_we;
            mem_wa = CNT_AW'(r_bin);
            mem_wd = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            r_v   <= i_acc;
            r_fwd <= i_acc && item_we && (r_bin == i_bin_index);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= n_count;
        if (i_acc) begin
            r_cmd   <= i_command;
            r_ws    <= i_ws_flag;
            r_bin   <= i_bin_index;
            r_frame <= i_frame_number;
            r_hidx  <= i_hist_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd <= r_mem[CNT_AW'(i_bin_index)];
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    `SWRD_ASSERT_IMP(a_fwd_has_item, r_fwd, r_v, "run counter forward without an item in stage")
    `SWRD_ASSERT_IMP(a_event_nonzero, is_event, o_req.run_length != '0, "event with zero run length")

endmodule

[design/swrd_hist_stage.sv]
// Histogram memory and the accumulate and readout stage.
`include "spectrum_whitespace_run_detector_macros.svh"

module swrd_hist_stage import swrd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_clear    i_clear,
    input  t_hist_req i_req,
    output logic      o_push,
    output t_result   o_res
);

    logic [SUM_W-1:0] r_mem [HIST_DEPTH];

    t_hist_req        r_req;
    logic [SUM_W-1:0] r_rd;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_val;

    logic [SUM_W-1:0]   cur;
    logic [SUM_W:0]     sum;
    logic [SUM_W-1:0]   n_sum;
    logic               item_we;
    logic               mem_we;
    logic [HIST_AW-1:0] mem_wa;
    logic [SUM_W-1:0]   mem_wd;

    always_comb begin
        cur     = r_fwd ? r_fwd_val : r_rd;
        sum     = {1'b0, cur} + (SUM_W + 1)'(r_req.run_length);
        n_sum   = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
        item_we = r_req.valid && r_req.add;

        if (i_clear.valid) begin
            mem_we = 32'(i_clear.addr) < HIST_DEPTH;
            mem_wa = HIST_AW'(i_clear.addr);
            mem_wd = '0;
        end else begin
            mem_we = item_we;
            mem_wa = r_req.hist_addr;
            mem_wd = n_sum;
        end

        o_push              = r_req.valid;
        o_res.result_kind   = r_req.kind;
        o_res.run_length    = r_req.run_length;
        o_res.event_bin     = r_req.event_bin;
        o_res.event_frame   = r_req.event_frame;
        o_res.hist_overflow = r_req.overflow;
        o_res.hist_value    = ((r_req.kind == KIND_READOUT) && !r_req.overflow) ? cur : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_req <= i_req;
            r_fwd <= i_req.valid && item_we && (i_req.hist_addr == r_req.hist_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_val <= n_sum;
        if (i_req.valid) begin
            r_rd <= r_mem[i_req.hist_addr];
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    `SWRD_ASSERT_IMP(a_add_is_event, item_we, r_req.kind == KIND_EVENT && !r_req.overflow, "histogram add from a readout or an overflowed run")

endmodule

[design/swrd_out_fifo.sv]
// Small result queue that decouples the pipeline from the output handshake.
`include "spectrum_whitespace_run_detector_macros.svh"

module swrd_out_fifo import swrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_data,
    output logic [OCNT_W-1:0] o_count
);

    localparam int PTR_W = $clog2(OUT_DEPTH);

    t_result           r_mem [OUT_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [OCNT_W-1:0] r_count;
    logic              pop;

    always_comb begin
        o_valid = r_count != '0;
        o_data  = r_mem[r_rd_ptr];
        o_count = r_count;
        pop     = o_valid && i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OCNT_W'(i_push) - OCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `SWRD_ASSERT_IMP(a_push_has_room, i_push, (r_count < OCNT_W'(OUT_DEPTH)) || pop, "result pushed into a full queue")

endmodule

[test/swrd_checker.sv]
// Scoreboard for the whitespace run detector: predicts every result and compares it.
module swrd_checker
    import swrd_pkg::*;
#(
    parameter logic [2:0] GUARD_ADDR   = 3'd0,
    parameter logic [2:0] HIST_EN_ADDR = 3'd4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_command,
    input  logic               i_ws_flag,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic [FRAME_W-1:0] i_frame_number,
    input  logic [HIDX_W-1:0]  i_hist_index,

    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_result_kind,
    input  logic [RUN_W-1:0]   i_run_length,
    input  logic [BIN_W-1:0]   i_event_bin,
    input  logic [FRAME_W-1:0] i_event_frame,
    input  logic               i_hist_overflow,
    input  logic [SUM_W-1:0]   i_hist_value,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,

    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copies of the block's state and registers.
    logic [RUN_W-1:0]   bin_runs [BINS];
    logic [SUM_W-1:0]   len_hist [HIST_DEPTH];
    logic [GUARD_W-1:0] guard_cfg;
    logic               hist_en_cfg;

    // Events and readouts still owed by the block, oldest first.
    t_result run_reports_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Works out the result of one item and updates the shadow state.
    task automatic detect_run_end(input logic cmd, input logic ws,
                                  input logic [BIN_W-1:0] bin,
                                  input logic [FRAME_W-1:0] frame,
                                  input logic [HIDX_W-1:0] hidx,
                                  output bit produced, output t_result res);
        logic [RUN_W-1:0] count;
        logic [SUM_W:0]   total;
        bit               active;
        int               slot;
        res      = '0;
        produced = 1'b0;
        if (cmd == CMD_READ) begin
            res.result_kind = KIND_READOUT;
            if (int'(hidx) < HIST_DEPTH)
                res.hist_value = len_hist[hidx];
            else
                res.hist_overflow = 1'b1;
            produced = 1'b1;
        end else if (int'(bin) < BINS) begin
            count  = bin_runs[bin];
            active = (2 * int'(guard_cfg) < BINS) && (int'(bin) >= int'(guard_cfg))
                     && (int'(bin) < BINS - int'(guard_cfg));
            if (active && !ws && count != '0) begin
                produced         = 1'b1;
                res.result_kind  = KIND_EVENT;
                res.run_length   = count;
                res.event_bin    = bin;
                res.event_frame  = frame;
                if (hist_en_cfg) begin
                    slot = int'(count) - 1;
                    if (slot >= HIST_DEPTH) begin
                        res.hist_overflow = 1'b1;
                    end else begin
                        total = {1'b0, len_hist[slot]} + count;
                        len_hist[slot] = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
                    end
                end
            end
            // The counter moves on every sample, guard bins included.
            if (ws)
                bin_runs[bin] = (count == RUN_MAX) ? RUN_MAX : count + 1'b1;
            else
                bin_runs[bin] = '0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result     want;
        bit          produced;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            foreach (bin_runs[k]) bin_runs[k] = '0;
            foreach (len_hist[k]) len_hist[k] = '0;
            guard_cfg   = 11'd409;
            hist_en_cfg = 1'b1;
            run_reports_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (run_reports_due.size() == 0) begin
                    report_mismatch("unexpected result (kind, bin)",
                                    64'({i_result_kind, i_event_bin}), '0);
                end else begin
                    want = run_reports_due.pop_front();
                    if (i_result_kind !== want.result_kind)
                        report_mismatch("result_kind", 64'(i_result_kind),
                                        64'(want.result_kind));
                    if (i_run_length !== want.run_length)
                        report_mismatch("run_length", 64'(i_run_length),
                                        64'(want.run_length));
                    if (i_event_bin !== want.event_bin)
                        report_mismatch("event_bin", 64'(i_event_bin), 64'(want.event_bin));
                    if (i_event_frame !== want.event_frame)
                        report_mismatch("event_frame", 64'(i_event_frame),
                                        64'(want.event_frame));
                    if (i_hist_overflow !== want.hist_overflow)
                        report_mismatch("hist_overflow", 64'(i_hist_overflow),
                                        64'(want.hist_overflow));
                    if (i_hist_value !== want.hist_value)
                        report_mismatch("hist_value", 64'(i_hist_value),
                                        64'(want.hist_value));
                end
            end
            if (i_in_valid && i_in_ready) begin
                detect_run_end(i_command, i_ws_flag, i_bin_index, i_frame_number,
                               i_hist_index, produced, want);
                if (produced)
                    run_reports_due = {run_reports_due, want};
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == GUARD_ADDR)
                        guard_cfg = pwdata[GUARD_W-1:0];
                    else if (paddr == HIST_EN_ADDR)
                        hist_en_cfg = pwdata[0];
                end else if (paddr == GUARD_ADDR || paddr == HIST_EN_ADDR) begin
                    reg_value = (paddr == GUARD_ADDR) ? {21'b0, guard_cfg}
                                                      : {31'b0, hist_en_cfg};
                    if (prdata !== reg_value)
                        report_mismatch("register read-back", 64'(prdata), 64'(reg_value));
                end
            end
        end
        o_pending = run_reports_due.size();
    end

endmodule

[test/tb.sv]
// Stimulus, handshake timing and verdict for the whitespace run detector testbench.
module tb;
    import swrd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Register map: guard width at word 0, histogram enable at word 1.
    localparam logic [2:0] GUARD_ADDR   = 3'd0;
    localparam logic [2:0] HIST_EN_ADDR = 3'd4;

    localparam logic FREE     = 1'b1;
    localparam logic OCCUPIED = 1'b0;

    // The pipeline holds a run counter stage and a histogram stage; items that leave no
    // result may still be inside it when the last expected result arrives.
    localparam int DRAIN_CYCLES   = 8;
    // The clearing pass after reset alone blocks the input while it clears 65536 entries.
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int HOLD_CYCLES    = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_command = CMD_SAMPLE;
    logic               i_ws_flag = OCCUPIED;
    logic [BIN_W-1:0]   i_bin_index = '0;
    logic [FRAME_W-1:0] i_frame_number = '0;
    logic [HIDX_W-1:0]  i_hist_index = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_result_kind;
    logic [RUN_W-1:0]   o_run_length;
    logic [BIN_W-1:0]   o_event_bin;
    logic [FRAME_W-1:0] o_event_frame;
    logic               o_hist_overflow;
    logic [SUM_W-1:0]   o_hist_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping.
    int               items_sent = 0;
    int               settings_done = 0;
    int               hold_requests = 0;
    int               holds_done = 0;
    bit               rx_calm = 1'b0;
    bit               tx_gappy = 1'b0;
    logic [FRAME_W-1:0] frame_now = '0;
    logic [BIN_W-1:0] hot_bins [8];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    spectrum_whitespace_run_detector u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_ws_flag       (i_ws_flag),
        .i_bin_index     (i_bin_index),
        .i_frame_number  (i_frame_number),
        .i_hist_index    (i_hist_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_run_length    (o_run_length),
        .o_event_bin     (o_event_bin),
        .o_event_frame   (o_event_frame),
        .o_hist_overflow (o_hist_overflow),
        .o_hist_value    (o_hist_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    swrd_checker #(
        .GUARD_ADDR   (GUARD_ADDR),
        .HIST_EN_ADDR (HIST_EN_ADDR)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_ws_flag       (i_ws_flag),
        .i_bin_index     (i_bin_index),
        .i_frame_number  (i_frame_number),
        .i_hist_index    (i_hist_index),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_result_kind   (o_result_kind),
        .i_run_length    (o_run_length),
        .i_event_bin     (o_event_bin),
        .i_event_frame   (o_event_frame),
        .i_hist_overflow (o_hist_overflow),
        .i_hist_value    (o_hist_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Result side. A requested hold keeps ready low for a long, fixed stretch so
    // that the result queue fills and the block stalls its input. Otherwise ready
    // drops in short random bursts, and stays high for good near the end.
    always begin
        @(negedge i_clk);
        if (hold_requests != holds_done) begin
            i_out_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            holds_done++;
        end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
        end else begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired after %0d idle cycles, %0d results outstanding.",
                 WATCHDOG_LIMIT, pending);
        $display("[spectrum_whitespace_run_detector] ERROR");
        $finish;
    end

    // Offers one item at a falling edge and returns at the falling edge after it
    // was taken; valid stays high so the next call can follow back to back.
    task automatic push_item(input logic cmd, input logic ws, input logic [BIN_W-1:0] bin,
                             input logic [FRAME_W-1:0] frame, input logic [HIDX_W-1:0] hidx);
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_ws_flag      <= ws;
        i_bin_index    <= bin;
        i_frame_number <= frame;
        i_hist_index   <= hidx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Holds the input until every expected result has come out, then lets the
    // pipeline run empty of items that leave no result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One APB transfer: setup phase, access phase, then idle with psel low.
    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Registers change only while the block is idle; each write is read back.
    task automatic set_config(input int guard, input bit hist_en);
        wait_drained();
        apb_transfer(1'b1, GUARD_ADDR, guard);
        apb_transfer(1'b1, HIST_EN_ADDR, {31'b0, hist_en});
        apb_transfer(1'b0, GUARD_ADDR, '0);
        apb_transfer(1'b0, HIST_EN_ADDR, '0);
        settings_done++;
    endtask

    // Bins around both band edges plus a few inside the band, so that runs build
    // up on a handful of bins and end often.
    task automatic pick_hot_bins(input int guard);
        hot_bins[0] = BIN_W'(guard - 1);
        hot_bins[1] = BIN_W'(guard);
        hot_bins[2] = BIN_W'(guard + 1);
        hot_bins[3] = BIN_W'(BINS - 1 - guard);
        hot_bins[4] = BIN_W'(BINS - guard);
        for (int k = 5; k < 8; k++)
            hot_bins[k] = BIN_W'($urandom_range(guard, BINS - 1 - guard));
    endtask

    // Mostly samples on the hot bins with free flags dominating, some histogram
    // reads of short lengths, and a little noise over the full field ranges.
    task automatic random_items(input int count);
        int          pick;
        logic        cmd;
        logic        ws;
        logic [BIN_W-1:0]  bin;
        logic [HIDX_W-1:0] hidx;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0)
                tx_gappy = !rx_calm && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            cmd  = (pick < 15) ? CMD_READ : CMD_SAMPLE;
            ws   = ($urandom_range(0, 9) < 7) ? FREE : OCCUPIED;
            bin  = hot_bins[$urandom_range(0, 7)];
            hidx = ($urandom_range(0, 4) == 0) ? HIDX_W'($urandom)
                                               : HIDX_W'($urandom_range(0, 15));
            if ($urandom_range(0, 19) == 0)
                frame_now = $urandom;
            else if ($urandom_range(0, 3) == 0)
                frame_now = frame_now + 1'b1;
            if (pick >= 92) begin
                cmd = 1'($urandom);
                bin = BIN_W'($urandom);
            end
            push_item(cmd, ws, bin, frame_now, hidx);
            if (tx_gappy && $urandom_range(0, 5) == 0)
                pause_input($urandom_range(1, 16));
        end
    endtask

    initial begin : stimulus
        int  guard;
        bit  hist_en;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Guard of zero: the outermost bins are inside the band. Items wait out
        // the clearing pass that follows reset.
        set_config(0, 1'b1);
        push_item(CMD_READ, OCCUPIED, '0, '0, '0);
        push_item(CMD_READ, OCCUPIED, '0, '0, '1);
        push_item(CMD_SAMPLE, FREE, '0, 32'd1, '0);
        push_item(CMD_SAMPLE, FREE, '0, 32'd2, '0);
        push_item(CMD_SAMPLE, OCCUPIED, '0, '1, '0);
        push_item(CMD_SAMPLE, FREE, '1, '0, '0);
        push_item(CMD_SAMPLE, OCCUPIED, '1, '0, '0);
        // An occupied bin that was already occupied ends no run.
        push_item(CMD_SAMPLE, OCCUPIED, '1, 32'd3, '0);
        push_item(CMD_SAMPLE, FREE, 12'hAAA, 32'hAAAA_AAAA, '0);
        push_item(CMD_SAMPLE, FREE, 12'hAAA, 32'hAAAA_AAAB, '0);
        push_item(CMD_SAMPLE, FREE, 12'hAAA, 32'hAAAA_AAAC, '0);
        push_item(CMD_SAMPLE, OCCUPIED, 12'hAAA, 32'h5555_5555, '0);
        push_item(CMD_READ, OCCUPIED, '0, '0, 16'd0);
        push_item(CMD_READ, OCCUPIED, '0, '0, 16'd1);
        push_item(CMD_READ, OCCUPIED, '0, '0, 16'd2);

        // Widest guard leaves only two active bins; histogram off, so runs
        // ending there are reported but not added.
        set_config(2047, 1'b0);
        push_item(CMD_SAMPLE, FREE, 12'd2046, 32'd10, '0);
        push_item(CMD_SAMPLE, OCCUPIED, 12'd2046, 32'd11, '0);
        push_item(CMD_SAMPLE, FREE, 12'd2047, 32'd10, '0);
        push_item(CMD_SAMPLE, OCCUPIED, 12'd2047, 32'd11, '0);
        push_item(CMD_SAMPLE, FREE, 12'd2048, 32'd10, '0);
        push_item(CMD_SAMPLE, FREE, 12'd2048, 32'd11, '0);
        push_item(CMD_SAMPLE, OCCUPIED, 12'd2048, 32'd12, '0);
        push_item(CMD_SAMPLE, FREE, 12'd2049, 32'd10, '0);
        push_item(CMD_SAMPLE, OCCUPIED, 12'd2049, 32'd11, '0);
        push_item(CMD_READ, OCCUPIED, '0, '0, 16'd0);

        // Random phases across several register settings.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin guard = 409;  hist_en = 1'b1; end
                1: begin guard = 0;    hist_en = 1'b1; end
                2: begin guard = 2047; hist_en = 1'b1; end
                3: begin guard = 1234; hist_en = 1'b0; end
                4: begin guard = 7;    hist_en = 1'b0; end
                5: begin guard = $urandom_range(0, 2047); hist_en = 1'($urandom); end
                default: begin guard = $urandom_range(0, 1023); hist_en = 1'b1; end
            endcase
            // The last phase runs with both sides moving every cycle.
            if (p == 6)
                rx_calm = 1'b1;
            set_config(guard, hist_en);
            pick_hot_bins(guard);
            if (p == 1) begin
                // Reads always produce a result, so a long output hold backs up
                // the queue and the input stalls while items keep being offered.
                hold_requests++;
                for (int n = 0; n < 40; n++)
                    push_item(CMD_READ, OCCUPIED, '0, frame_now,
                              HIDX_W'($urandom_range(0, 15)));
                wait_drained();
            end
            random_items((p == 6) ? 100 : 115);
        end

        wait_drained();
        $display("Sent %0d items over %0d register settings, including a long output hold.",
                 items_sent, settings_done);
        $display("Checked %0d events and readouts; %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[spectrum_whitespace_run_detector] OK");
        end else begin
            $display("[spectrum_whitespace_run_detector] ERROR");
        end
        $finish;
    end

endmodule
